@@ sv/line_rect_clipper_macros.svh @@
// Assertion macros shared by the line rectangle clipper RTL.
`ifndef LINE_RECT_CLIPPER_MACROS_SVH
`define LINE_RECT_CLIPPER_MACROS_SVH

// Check that prop holds in the same cycle as cond.
`define LRC_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check that prop holds in the cycle after cond.
`define LRC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ sv/lrc_pkg.sv @@
// Shared widths, register indexes and status type of the line rectangle clipper.
`timescale 1ns / 1ps

package lrc_pkg;

  localparam int WIN_BITS     = 14;
  localparam int EDGE_BITS    = WIN_BITS + 2;
  localparam int IN_BITS      = 16;
  localparam int OUT_BITS     = 16;
  localparam int PAL_BITS     = 8;
  localparam int COLOR_BITS   = 32;
  localparam int REG_IDX_BITS = 2;

  localparam logic [REG_IDX_BITS-1:0] REG_LEFT   = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_TOP    = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_WIDTH  = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
  } clu_status_t;

endpackage

@@ sv/line_rect_clipper.sv @@
// Top level of the line rectangle clipper: sequencer, window registers and result port.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ----------------------------------------
//  request   in         start & !busy             start_x start_y end_x end_y
//                                                 palette_index true_color
//  result    out        done (one-cycle strobe)   visible out_start_x out_start_y
//                                                 out_end_x out_end_y out_palette_index
//                                                 out_true_color
//  config    in         wr_en                     wr_index wr_data
//
//  A request goes through endpoint ordering, then passes of a rejection test and
//  an edge check per edge, with a clip on the shared clip unit for each edge hit,
//  and then emit and the result strobe. The clip unit's divider is P bits wide,
//  P = COORD_BITS + max(COORD_BITS, 16) + 2. After the pass cap one final
//  rejection test is made before the segment is emitted.
//  busy stays high for the whole request; the result strobe cannot be stalled.
//  Reset (rst, synchronous) restores the window to 0, 0, 320 x 200 and idles the
//  sequencer; write the window only while busy is low.
//
`include "line_rect_clipper_macros.svh"

module line_rect_clipper import lrc_pkg::*; #(
  parameter int MAX_PASSES = 4,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic signed [IN_BITS-1:0]    start_x,
  input  logic signed [IN_BITS-1:0]    start_y,
  input  logic signed [IN_BITS-1:0]    end_x,
  input  logic signed [IN_BITS-1:0]    end_y,
  input  logic [PAL_BITS-1:0]          palette_index,
  input  logic [COLOR_BITS-1:0]        true_color,
  // configuration write port
  input  logic                         wr_en,
  input  logic [REG_IDX_BITS-1:0]      wr_index,
  input  logic [WIN_BITS-1:0]          wr_data,
  // result channel
  output logic                         done,
  output logic                         visible,
  output logic signed [OUT_BITS-1:0]   out_start_x,
  output logic signed [OUT_BITS-1:0]   out_start_y,
  output logic signed [OUT_BITS-1:0]   out_end_x,
  output logic signed [OUT_BITS-1:0]   out_end_y,
  output logic [PAL_BITS-1:0]          out_palette_index,
  output logic [COLOR_BITS-1:0]        out_true_color
);

  // coordinate registers must hold both saturated coordinates and window edges
  localparam int CW        = (COORD_BITS > EDGE_BITS) ? COORD_BITS : EDGE_BITS;
  localparam int DW        = COORD_BITS + 1;
  localparam int PASS_BITS = $clog2(MAX_PASSES + 1);

  localparam logic signed [CW-1:0] C_MAX = CW'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [CW-1:0] C_MIN = -C_MAX - CW'(1);
  localparam logic signed [CW:0]   O_MAX = (CW + 1)'((1 << (OUT_BITS - 1)) - 1);
  localparam logic signed [CW:0]   O_MIN = -O_MAX - (CW + 1)'(1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_REJ   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_ENDP  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  // window edges, visited in this order each pass
  localparam logic [1:0] E_LEFT  = 2'd0;
  localparam logic [1:0] E_RIGHT = 2'd1;
  localparam logic [1:0] E_TOP   = 2'd2;
  localparam logic [1:0] E_BOT   = 2'd3;

  // window registers
  logic signed [WIN_BITS-1:0]  win_left;
  logic signed [WIN_BITS-1:0]  win_top;
  logic [WIN_BITS-1:0]         win_width;
  logic [WIN_BITS-1:0]         win_height;
  logic signed [EDGE_BITS-1:0] right_r;
  logic signed [EDGE_BITS-1:0] bottom_r;

  // sequencer and segment state
  logic [2:0]              state;
  logic [1:0]              edge_sel;
  logic [PASS_BITS-1:0]    pass_cnt;
  logic                    clipped;
  logic                    vis_r;
  logic                    inc;
  logic signed [CW-1:0]    x0;
  logic signed [CW-1:0]    y0;
  logic signed [CW-1:0]    x1;
  logic signed [CW-1:0]    y1;
  logic signed [CW-1:0]    ymin;
  logic signed [CW-1:0]    ymax;
  logic signed [DW-1:0]    dx;
  logic signed [DW-1:0]    dy;
  logic [PAL_BITS-1:0]     pal_r;
  logic [COLOR_BITS-1:0]   color_r;

  // clip unit interface
  logic                        clu_start;
  clu_status_t                 clu_stat;
  logic signed [CW-1:0]        op_base;
  logic signed [EDGE_BITS-1:0] op_bound;
  logic signed [CW-1:0]        op_cur;
  logic signed [DW-1:0]        op_mul;
  logic signed [DW-1:0]        op_div;
  logic signed [COORD_BITS-1:0] clu_result;
  logic signed [CW-1:0]        clu_ext;

  logic swap;
  logic rejected;
  logic edge_hit;

  function automatic logic signed [CW-1:0] sat_in(input logic signed [IN_BITS-1:0] v);
    logic signed [CW-1:0] w;
    w = CW'(v);
    if (w > C_MAX) begin
      return C_MAX;
    end else if (w < C_MIN) begin
      return C_MIN;
    end
    return w;
  endfunction

  function automatic logic signed [OUT_BITS-1:0] clamp_out(input logic signed [CW:0] v);
    if (v > O_MAX) begin
      return O_MAX[OUT_BITS-1:0];
    end else if (v < O_MIN) begin
      return O_MIN[OUT_BITS-1:0];
    end
    return v[OUT_BITS-1:0];
  endfunction

  assign busy    = (state != S_IDLE);
  assign swap    = (x0 > x1);
  assign clu_ext = CW'(clu_result);

  // whole segment outside the window: left of it, above, right of it or below
  assign rejected = (x1 < win_left) || (ymax < win_top) ||
                    (x0 > right_r) || (ymin > bottom_r);

  // edge test uses the y span from the start of the pass
  always_comb begin
    unique case (edge_sel)
      E_LEFT:  edge_hit = (x0 < win_left);
      E_RIGHT: edge_hit = (x1 > right_r);
      E_TOP:   edge_hit = (ymin < win_top);
      E_BOT:   edge_hit = (ymax > bottom_r);
    endcase
  end

  // steer the current edge's operands into the shared clip unit
  always_comb begin
    op_base  = y0;
    op_bound = EDGE_BITS'(win_left);
    op_cur   = x0;
    op_mul   = dy;
    op_div   = dx;
    unique case (edge_sel)
      E_LEFT: begin
        op_base  = y0;
        op_bound = EDGE_BITS'(win_left);
        op_cur   = x0;
      end
      E_RIGHT: begin
        op_base  = y1;
        op_bound = right_r;
        op_cur   = x1;
      end
      E_TOP: begin
        op_mul   = dx;
        op_div   = dy;
        op_bound = EDGE_BITS'(win_top);
        op_base  = inc ? x1 : x0;
        op_cur   = inc ? y1 : y0;
      end
      E_BOT: begin
        op_mul   = dx;
        op_div   = dy;
        op_bound = bottom_r;
        op_base  = inc ? x0 : x1;
        op_cur   = inc ? y0 : y1;
      end
    endcase
  end

  assign clu_start = (state == S_CHECK) && edge_hit;

  lrc_clip_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_clip (
    .clk    (clk),
    .rst    (rst),
    .start  (clu_start),
    .base   (op_base),
    .bound  (op_bound),
    .cur    (op_cur),
    .mul_a  (op_mul),
    .div_d  (op_div),
    .status (clu_stat),
    .result (clu_result)
  );

  // window registers: the user must write them only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left   <= '0;
      win_top    <= '0;
      win_width  <= WIN_BITS'(320);
      win_height <= WIN_BITS'(200);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_LEFT:   win_left   <= $signed(wr_data);
        REG_TOP:    win_top    <= $signed(wr_data);
        REG_WIDTH:  win_width  <= wr_data;
        REG_HEIGHT: win_height <= wr_data;
      endcase
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      edge_sel <= E_LEFT;
      pass_cnt <= '0;
      clipped  <= 1'b0;
      vis_r    <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_PREP;
        end
        S_PREP: begin
          pass_cnt <= '0;
          state    <= S_REJ;
        end
        S_REJ: begin
          if (rejected) begin
            vis_r <= 1'b0;
            state <= S_EMIT;
          end else if (pass_cnt == PASS_BITS'(MAX_PASSES)) begin
            // pass cap reached and the segment still overlaps: emit as it stands
            vis_r <= 1'b1;
            state <= S_EMIT;
          end else begin
            clipped  <= 1'b0;
            edge_sel <= E_LEFT;
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (edge_hit) begin
            clipped <= 1'b1;
            state   <= S_WAIT;
          end else if (edge_sel == E_BOT) begin
            state <= S_ENDP;
          end else begin
            edge_sel <= edge_sel + 1'b1;
          end
        end
        S_WAIT: begin
          if (clu_stat.done) begin
            if (edge_sel == E_BOT) begin
              state <= S_ENDP;
            end else begin
              edge_sel <= edge_sel + 1'b1;
              state    <= S_CHECK;
            end
          end
        end
        S_ENDP: begin
          if (!clipped) begin
            vis_r <= 1'b1;
            state <= S_EMIT;
          end else begin
            pass_cnt <= pass_cnt + 1'b1;
            state    <= S_REJ;
          end
        end
        S_EMIT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // segment datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          x0      <= sat_in(start_x);
          y0      <= sat_in(start_y);
          x1      <= sat_in(end_x);
          y1      <= sat_in(end_y);
          pal_r   <= palette_index;
          color_r <= true_color;
        end
      end
      S_PREP: begin
        // order endpoints by x; slopes come from the ordered segment
        if (swap) begin
          x0 <= x1;
          y0 <= y1;
          x1 <= x0;
          y1 <= y0;
          dx <= DW'(x0) - DW'(x1);
          dy <= DW'(y0) - DW'(y1);
          inc <= (y0 <= y1);
        end else begin
          dx <= DW'(x1) - DW'(x0);
          dy <= DW'(y1) - DW'(y0);
          inc <= (y0 >= y1);
        end
        ymin     <= (y0 < y1) ? y0 : y1;
        ymax     <= (y0 < y1) ? y1 : y0;
        right_r  <= EDGE_BITS'(win_left) + $signed({2'b00, win_width}) - EDGE_BITS'(1);
        bottom_r <= EDGE_BITS'(win_top) + $signed({2'b00, win_height}) - EDGE_BITS'(1);
      end
      S_WAIT: begin
        // write the clipped coordinate and snap the other one to the edge
        if (clu_stat.done) begin
          unique case (edge_sel)
            E_LEFT: begin
              y0 <= clu_ext;
              x0 <= CW'(win_left);
            end
            E_RIGHT: begin
              y1 <= clu_ext;
              x1 <= CW'(right_r);
            end
            E_TOP: begin
              if (inc) begin
                x1 <= clu_ext;
                y1 <= CW'(win_top);
              end else begin
                x0 <= clu_ext;
                y0 <= CW'(win_top);
              end
            end
            E_BOT: begin
              if (inc) begin
                x0 <= clu_ext;
                y0 <= CW'(bottom_r);
              end else begin
                x1 <= clu_ext;
                y1 <= CW'(bottom_r);
              end
            end
          endcase
        end
      end
      S_ENDP: begin
        // refresh the y span for the next pass
        if (clipped) begin
          ymin <= inc ? y1 : y0;
          ymax <= inc ? y0 : y1;
        end
      end
      default: begin
      end
    endcase
  end

  // result registers: hold until the next strobe
  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      visible           <= vis_r;
      out_palette_index <= pal_r;
      out_true_color    <= color_r;
      if (vis_r) begin
        out_start_x <= clamp_out((CW + 1)'(x0));
        out_start_y <= clamp_out((CW + 1)'(y0) + (CW + 1)'(1));
        out_end_x   <= clamp_out((CW + 1)'(x1));
        out_end_y   <= clamp_out((CW + 1)'(y1) + (CW + 1)'(1));
      end else begin
        out_start_x <= '0;
        out_start_y <= '0;
        out_end_x   <= '0;
        out_end_y   <= '0;
      end
    end
  end

  // checks
  `LRC_ASSERT_IMPLY(a_cull_zero, done && !visible, out_start_x == 0 && out_start_y == 0 && out_end_x == 0 && out_end_y == 0, "culled result carries coordinates")
  `LRC_ASSERT_IMPLY(a_clip_in_wait, clu_stat.busy, state == S_WAIT, "clip unit busy outside wait state")
  `LRC_ASSERT_IMPLY(a_pass_cap, 1'b1, pass_cnt <= PASS_BITS'(MAX_PASSES), "pass count past cap")
  `LRC_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule

@@ sv/lrc_divider.sv @@
// Unsigned restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps

module lrc_divider #(
  parameter int NUM_BITS = 34,
  parameter int DEN_BITS = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quo
);

  localparam int PAD_BITS = NUM_BITS + (NUM_BITS % 2);
  localparam int STEPS    = PAD_BITS / 2;
  localparam int RW       = DEN_BITS + 1;
  localparam int CNT_BITS = $clog2(STEPS + 1);

  logic [RW-1:0]       rem_r;
  logic [PAD_BITS-1:0] quo_r;
  logic [DEN_BITS-1:0] den_r;
  logic [CNT_BITS-1:0] cnt;
  logic [RW-1:0]       rem_next;
  logic [PAD_BITS-1:0] quo_next;

  // two shift-compare-subtract steps; numerator bits shift out as quotient bits shift in
  always_comb begin
    rem_next = rem_r;
    quo_next = quo_r;
    for (int i = 0; i < 2; i++) begin
      rem_next = {rem_next[RW-2:0], quo_next[PAD_BITS-1]};
      quo_next = {quo_next[PAD_BITS-2:0], 1'b0};
      if (rem_next >= {1'b0, den_r}) begin
        rem_next    = rem_next - {1'b0, den_r};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_BITS'(STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= PAD_BITS'(num);
      den_r <= den;
    end else if (cnt != '0) begin
      rem_r <= rem_next;
      quo_r <= quo_next;
    end
  end

  assign quo = quo_r[NUM_BITS-1:0];

endmodule

@@ sv/lrc_clip_unit.sv @@
// Shared clip unit: base + (mul * (bound - cur)) / div, truncated, then saturated.
`timescale 1ns / 1ps

module lrc_clip_unit import lrc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [((COORD_BITS > EDGE_BITS) ? COORD_BITS : EDGE_BITS)-1:0] base,
  input  logic signed [EDGE_BITS-1:0]   bound,
  input  logic signed [((COORD_BITS > EDGE_BITS) ? COORD_BITS : EDGE_BITS)-1:0] cur,
  input  logic signed [COORD_BITS:0]    mul_a,
  input  logic signed [COORD_BITS:0]    div_d,
  output clu_status_t                   status,
  output logic signed [COORD_BITS-1:0]  result
);

  localparam int CW = (COORD_BITS > EDGE_BITS) ? COORD_BITS : EDGE_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + CW + 1;
  localparam int SW = PW + 2;

  localparam logic signed [SW-1:0] S_MAX = SW'((1 << (COORD_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] S_MIN = -S_MAX - SW'(1);

  localparam logic [2:0] CU_IDLE = 3'd0;
  localparam logic [2:0] CU_MUL  = 3'd1;
  localparam logic [2:0] CU_ABS  = 3'd2;
  localparam logic [2:0] CU_DIV  = 3'd3;
  localparam logic [2:0] CU_ADD  = 3'd4;

  logic [2:0]            state;
  logic                  done_r;
  logic                  zero_r;
  logic                  neg_r;
  logic signed [CW-1:0]  base_r;
  logic signed [DW-1:0]  mul_r;
  logic signed [DW-1:0]  den_r;
  logic signed [CW:0]    diff_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [PW:0]    prod_ext;
  logic [PW:0]           prod_mag;
  logic [DW:0]           den_ext;
  logic [DW:0]           den_mag;
  logic                  div_start;
  logic                  div_done;
  logic [PW-1:0]         div_quo;
  logic [PW-1:0]         q_mag;
  logic signed [PW:0]    q_s;
  logic signed [SW-1:0]  sum;

  assign prod_ext  = {prod_r[PW-1], prod_r};
  assign prod_mag  = prod_r[PW-1] ? unsigned'(-prod_ext) : unsigned'(prod_ext);
  assign den_ext   = {den_r[DW-1], den_r};
  assign den_mag   = den_r[DW-1] ? (~den_ext + 1'b1) : den_ext;
  assign div_start = (state == CU_ABS) && !zero_r;

  lrc_divider #(
    .NUM_BITS (PW),
    .DEN_BITS (DW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod_mag[PW-1:0]),
    .den   (den_mag[DW-1:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  // a zero divisor contributes nothing
  assign q_mag = zero_r ? '0 : div_quo;
  assign q_s   = neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign sum   = SW'(base_r) + SW'(q_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= CU_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state)
        CU_IDLE: if (start) state <= CU_MUL;
        CU_MUL:  state <= CU_ABS;
        CU_ABS:  state <= zero_r ? CU_ADD : CU_DIV;
        CU_DIV:  if (div_done) state <= CU_ADD;
        CU_ADD: begin
          done_r <= 1'b1;
          state  <= CU_IDLE;
        end
        default: state <= CU_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == CU_IDLE && start) begin
      base_r <= base;
      mul_r  <= mul_a;
      den_r  <= div_d;
      zero_r <= (div_d == '0);
      diff_r <= (CW + 1)'(bound) - (CW + 1)'(cur);
    end
    if (state == CU_MUL) begin
      prod_r <= mul_r * diff_r;
    end
    if (state == CU_ABS) begin
      neg_r <= prod_r[PW-1] ^ den_r[DW-1];
    end
    if (state == CU_ADD) begin
      if (sum > S_MAX) begin
        result <= S_MAX[COORD_BITS-1:0];
      end else if (sum < S_MIN) begin
        result <= S_MIN[COORD_BITS-1:0];
      end else begin
        result <= sum[COORD_BITS-1:0];
      end
    end
  end

  assign status.busy = (state != CU_IDLE);
  assign status.done = done_r;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the line rectangle clipper: driver, predictor and result monitor.
`timescale 1ns / 1ps

module tb;
  import lrc_pkg::*;

  // Must match the parameters the block is built with below.
  localparam int MAX_PASSES = 4;
  localparam int COORD_BITS = 16;

  // Watchdog limit on the run: all 1224 requests, even at the slowest,
  // with sender gaps on top, stay well below this.
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 100;
  localparam int PHASES      = 12;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic signed [IN_BITS-1:0] x0;
    logic signed [IN_BITS-1:0] y0;
    logic signed [IN_BITS-1:0] x1;
    logic signed [IN_BITS-1:0] y1;
    logic [PAL_BITS-1:0]       pal;
    logic [COLOR_BITS-1:0]     color;
  } segment_t;

  typedef struct {
    logic                       visible;
    logic signed [OUT_BITS-1:0] sx;
    logic signed [OUT_BITS-1:0] sy;
    logic signed [OUT_BITS-1:0] ex;
    logic signed [OUT_BITS-1:0] ey;
    logic [PAL_BITS-1:0]        pal;
    logic [COLOR_BITS-1:0]      color;
  } clip_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Request channel, all driven to known values from time zero.
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [IN_BITS-1:0] start_x = '0;
  logic signed [IN_BITS-1:0] start_y = '0;
  logic signed [IN_BITS-1:0] end_x = '0;
  logic signed [IN_BITS-1:0] end_y = '0;
  logic [PAL_BITS-1:0]       palette_index = '0;
  logic [COLOR_BITS-1:0]     true_color = '0;

  // Window register port.
  logic                    wr_en = 1'b0;
  logic [REG_IDX_BITS-1:0] wr_index = REG_LEFT;
  logic [WIN_BITS-1:0]     wr_data = '0;

  // Result channel.
  logic                       done;
  logic                       visible;
  logic signed [OUT_BITS-1:0] out_start_x;
  logic signed [OUT_BITS-1:0] out_start_y;
  logic signed [OUT_BITS-1:0] out_end_x;
  logic signed [OUT_BITS-1:0] out_end_y;
  logic [PAL_BITS-1:0]        out_palette_index;
  logic [COLOR_BITS-1:0]      out_true_color;

  // Predictor copy of the window registers (reset values).
  longint win_left   = 0;
  longint win_top    = 0;
  longint win_width  = 320;
  longint win_height = 200;

  segment_t     pending_requests[$];
  clip_result_t expected_clips[$];
  segment_t     driven_seg;
  bit           slot_free;
  int           idle_pct = 6;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  line_rect_clipper #(
    .MAX_PASSES(MAX_PASSES),
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .palette_index(palette_index),
    .true_color(true_color),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data),
    .done(done),
    .visible(visible),
    .out_start_x(out_start_x),
    .out_start_y(out_start_y),
    .out_end_x(out_end_x),
    .out_end_y(out_end_y),
    .out_palette_index(out_palette_index),
    .out_true_color(out_true_color)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Saturate to the block's internal signed coordinate range.
  function automatic longint sat_coord(longint v);
    longint hi;
    hi = (longint'(1) << (COORD_BITS - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Saturate to the signed width of an output port.
  function automatic logic signed [OUT_BITS-1:0] sat_out(longint v);
    longint hi;
    hi = (longint'(1) << (OUT_BITS - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return OUT_BITS'(v);
  endfunction

  // True when the bounding box lies wholly outside the window.
  function automatic bit window_miss(longint xa, longint xb, longint ylo, longint yhi);
    return xb < win_left || yhi < win_top || xa >= win_left + win_width ||
           ylo >= win_top + win_height;
  endfunction

  // Truncating division; a zero divisor contributes nothing.
  function automatic longint div_trunc(longint n, longint d);
    if (d == 0) return 0;
    return n / d;
  endfunction

  function automatic clip_result_t predict_clip(segment_t s);
    longint x0, y0, x1, y1, dx, dy, ylo, yhi, tmp, right, bottom;
    bit falling, clipped, settled, shown;
    clip_result_t r;
    x0 = sat_coord(longint'(s.x0));
    y0 = sat_coord(longint'(s.y0));
    x1 = sat_coord(longint'(s.x1));
    y1 = sat_coord(longint'(s.y1));
    right = win_left + win_width - 1;
    bottom = win_top + win_height - 1;
    settled = 1'b0;
    shown = 1'b1;
    r.pal = s.pal;
    r.color = s.color;
    // Order the endpoints left to right; slopes come from the ordered segment.
    if (x0 > x1) begin
      tmp = x0; x0 = x1; x1 = tmp;
      tmp = y0; y0 = y1; y1 = tmp;
    end
    dx = x1 - x0;
    dy = y1 - y0;
    ylo = (y0 < y1) ? y0 : y1;
    yhi = (y0 < y1) ? y1 : y0;
    falling = (yhi == y0);
    for (int p = 0; p < MAX_PASSES; p++) begin
      if (window_miss(x0, x1, ylo, yhi)) begin
        shown = 1'b0;
        break;
      end
      clipped = 1'b0;
      if (x0 < win_left) begin
        clipped = 1'b1;
        y0 = sat_coord(y0 + div_trunc(dy * (win_left - x0), dx));
        x0 = win_left;
      end
      if (x1 > right) begin
        clipped = 1'b1;
        y1 = sat_coord(y1 + div_trunc(dy * (right - x1), dx));
        x1 = right;
      end
      if (ylo < win_top) begin
        clipped = 1'b1;
        if (falling) begin
          x1 = sat_coord(x1 + div_trunc(dx * (win_top - y1), dy));
          y1 = win_top;
        end else begin
          x0 = sat_coord(x0 + div_trunc(dx * (win_top - y0), dy));
          y0 = win_top;
        end
      end
      if (yhi > bottom) begin
        clipped = 1'b1;
        if (falling) begin
          x0 = sat_coord(x0 + div_trunc(dx * (bottom - y0), dy));
          y0 = bottom;
        end else begin
          x1 = sat_coord(x1 + div_trunc(dx * (bottom - y1), dy));
          y1 = bottom;
        end
      end
      if (!clipped) begin
        settled = 1'b1;
        break;
      end
      ylo = falling ? y1 : y0;
      yhi = falling ? y0 : y1;
    end
    // Pass cap hit: one last rejection, then emit as it stands.
    if (shown && !settled && window_miss(x0, x1, ylo, yhi)) shown = 1'b0;
    r.visible = shown;
    r.sx = shown ? sat_out(x0) : '0;
    r.sy = shown ? sat_out(y0 + 1) : '0;
    r.ex = shown ? sat_out(x1) : '0;
    r.ey = shown ? sat_out(y1 + 1) : '0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_REPORTS) $display("mismatch @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Write one window register and mirror it into the predictor.
  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, longint value);
    logic [WIN_BITS-1:0] bits_v;
    bits_v = WIN_BITS'(value);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= bits_v;
    case (idx)
      REG_LEFT:   win_left = longint'(signed'(bits_v));
      REG_TOP:    win_top = longint'(signed'(bits_v));
      REG_WIDTH:  win_width = longint'(bits_v);
      REG_HEIGHT: win_height = longint'(bits_v);
      default: ;
    endcase
  endtask

  task automatic set_window(longint left, longint top, longint width, longint height);
    write_reg(REG_LEFT, left);
    write_reg(REG_TOP, top);
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic push_seg(longint x0, longint y0, longint x1, longint y1,
                          logic [PAL_BITS-1:0] pal, logic [COLOR_BITS-1:0] color);
    segment_t s;
    s.x0 = IN_BITS'(x0);
    s.y0 = IN_BITS'(y0);
    s.x1 = IN_BITS'(x1);
    s.y1 = IN_BITS'(y1);
    s.pal = pal;
    s.color = color;
    pending_requests.push_back(s);
  endtask

  // Mostly near the window so clips happen, sometimes on an edge, sometimes anywhere.
  function automatic longint pick_coord(longint lo, longint size);
    longint v, span;
    span = size + 2;
    case ($urandom_range(0, 9))
      0: v = longint'($urandom_range(0, 65535)) - 32768;
      1: v = $urandom_range(0, 1) ? 32767 : -32768;
      2: begin
        case ($urandom_range(0, 3))
          0: v = lo - 1;
          1: v = lo;
          2: v = lo + size - 1;
          default: v = lo + size;
        endcase
      end
      default: v = lo - span + longint'($urandom_range(0, 3 * span));
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic push_random_seg();
    longint x0, y0, x1, y1;
    x0 = pick_coord(win_left, win_width);
    y0 = pick_coord(win_top, win_height);
    x1 = pick_coord(win_left, win_width);
    y1 = pick_coord(win_top, win_height);
    // Some horizontal and vertical lines, where one slope term is zero.
    case ($urandom_range(0, 11))
      0: y1 = y0;
      1: x1 = x0;
      default: ;
    endcase
    push_seg(x0, y0, x1, y1, PAL_BITS'($urandom), $urandom);
  endtask

  // Hold until every request has gone through and every result has come back.
  task automatic drain_requests();
    do @(posedge clk);
    while (pending_requests.size() != 0 || start || busy || expected_clips.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present the next request once the previous one is taken.
  // A request is accepted at an edge with start high and busy low; predict it
  // there, with the window as it stands.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_clips.push_back(predict_clip(driven_seg));
        slot_free = 1'b1;
      end else begin
        slot_free = !start;
      end
      // Only one assignment to start per edge: keep it high for a back-to-back request.
      if (slot_free) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          driven_seg = pending_requests.pop_front();
          start_x <= driven_seg.x0;
          start_y <= driven_seg.y0;
          end_x <= driven_seg.x1;
          end_y <= driven_seg.y1;
          palette_index <= driven_seg.pal;
          true_color <= driven_seg.color;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: each done strobe carries one result; compare it with the oldest
  // prediction field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    clip_result_t want;
    if (!rst && done) begin
      if (expected_clips.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = expected_clips.pop_front();
        if (visible !== want.visible)
          report_mismatch($sformatf("visible %b, want %b", visible, want.visible));
        if (out_start_x !== want.sx)
          report_mismatch($sformatf("out_start_x %0d, want %0d", out_start_x, want.sx));
        if (out_start_y !== want.sy)
          report_mismatch($sformatf("out_start_y %0d, want %0d", out_start_y, want.sy));
        if (out_end_x !== want.ex)
          report_mismatch($sformatf("out_end_x %0d, want %0d", out_end_x, want.ex));
        if (out_end_y !== want.ey)
          report_mismatch($sformatf("out_end_y %0d, want %0d", out_end_y, want.ey));
        if (out_palette_index !== want.pal)
          report_mismatch($sformatf("out_palette_index %h, want %h",
                                    out_palette_index, want.pal));
        if (out_true_color !== want.color)
          report_mismatch($sformatf("out_true_color %h, want %h",
                                    out_true_color, want.color));
      end
    end
  end

  // Watchdog: a stuck handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed requests on the reset window, then phases of
  // random requests, each on a fresh window written while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed requests against the reset window 0,0 320x200.
    idle_pct = 6;
    push_seg(10, 10, 100, 50, 8'h00, 32'h0000_0000);           // fully inside
    push_seg(300, 150, 5, 5, 8'hFF, 32'hFFFF_FFFF);            // endpoints swapped
    push_seg(-32768, -32768, 32767, 32767, 8'h00, 32'hFFFF_FFFF);
    push_seg(32767, -32768, -32768, 32767, 8'hFF, 32'h0000_0000);
    push_seg(-100, 10, -5, 50, 8'h5A, 32'h1234_5678);          // culled, left
    push_seg(400, 10, 500, 50, 8'hA5, 32'h8765_4321);          // culled, right
    push_seg(10, -50, 100, -1, 8'h01, 32'h0000_0001);          // culled, above
    push_seg(10, 200, 100, 300, 8'h80, 32'h8000_0000);         // culled, below
    push_seg(-50, 20, 400, 20, 8'h7F, 32'h7FFF_FFFF);          // horizontal, both sides
    push_seg(50, -100, 50, 500, 8'hFE, 32'hFFFF_FFFE);         // vertical, top and bottom
    push_seg(0, 0, 319, 199, 8'h11, 32'hAAAA_AAAA);            // exactly on the edges
    push_seg(-1, -1, 320, 200, 8'h22, 32'h5555_5555);          // one past every edge
    push_seg(160, 100, 160, 100, 8'h33, 32'h0F0F_0F0F);        // single point inside
    push_seg(-5, -5, -5, -5, 8'h44, 32'hF0F0_F0F0);            // single point outside
    push_seg(-200, 150, 150, -300, 8'h55, 32'h0123_4567);      // steep, several clips
    push_seg(-1000, -900, 1200, 1300, 8'h66, 32'h89AB_CDEF);
    push_seg(-400, 190, 400, 210, 8'h77, 32'hDEAD_BEEF);       // shallow over the bottom
    push_seg(330, -10, -10, 210, 8'h88, 32'hCAFE_F00D);        // clipped on every edge
    push_seg(-10, -3, 330, -1, 8'h99, 32'h0000_FFFF);          // grazing the top, culled
    push_seg(319, -32768, 319, 32767, 8'hAA, 32'hFFFF_0000);   // vertical on the right edge
    push_seg(0, 199, 319, 0, 8'hBB, 32'h00FF_00FF);
    push_seg(-10, 5, 5, -10, 8'hCC, 32'hFF00_FF00);            // misses the corner: keeps clipping
    push_seg(310, -5, 325, 8, 8'hDD, 32'h3C3C_3C3C);
    push_seg(-1000, 10, 10, -1000, 8'hEE, 32'hC3C3_C3C3);
    drain_requests();

    for (int ph = 0; ph < PHASES; ph++) begin
      // Sender gaps: light, then heavy, then none.
      idle_pct = (ph < 4) ? 6 : ((ph < 8) ? 53 : 0);
      case (ph)
        0: set_window(0, 0, 320, 200);
        1: set_window(-1, -1, 8192, 8192);
        2: set_window(8191, 8191, 8192, 8192);
        3: set_window(100, 50, 0, 30);        // empty width: everything culled
        4: set_window(10, 20, 64, 0);         // empty height: everything culled
        5: set_window(-1, 8191, 1, 1);
        default: set_window(longint'($urandom_range(0, 8192)) - 1,
                            longint'($urandom_range(0, 8192)) - 1,
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 8192)
                                                      : $urandom_range(1, 400),
                            $urandom_range(0, 3) == 0 ? $urandom_range(0, 8192)
                                                      : $urandom_range(1, 400));
      endcase
      repeat (PHASE_ITEMS) push_random_seg();
      drain_requests();
    end

    // Let any stray strobe show up before closing.
    repeat (400) @(posedge clk);
    if (expected_clips.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_clips.size()));
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
